// File: rtl/spl_pkg.sv
// ----------------------------------------------------------------------------
// spl_pkg
// Shared types, constants and calibration tables of the sensor piecewise
// linearizer.
// ----------------------------------------------------------------------------
package spl_pkg;

	// Field widths.
	localparam int KIND_W  = 2;
	localparam int COUNT_W = 12;
	localparam int VALUE_W = 12;

	// Segment index inside one table and flat address into the joined table.
	localparam int IDX_W  = 6;
	localparam int ADDR_W = 7;
	localparam int PT_N   = 76;

	// Arithmetic widths. Every interpolated magnitude is below 2048, so the
	// quotient needs eleven bits and the numerator magnitude 23 bits.
	localparam int DY_W   = VALUE_W + 1;
	localparam int PA_W   = VALUE_W + COUNT_W + 1;
	localparam int PB_W   = COUNT_W + 1 + DY_W;
	localparam int NUM_W  = PB_W + 1;
	localparam int QUOT_W = 11;
	localparam int MAG_W  = QUOT_W + COUNT_W;
	localparam int BIT_W  = $clog2(QUOT_W);

	// Sensor kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_TEMP  = 2'd0,
		KIND_SOUND = 2'd1,
		KIND_LIGHT = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MUL_A,
		ST_MUL_B,
		ST_DIVIDE,
		ST_WRITE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic search;
		logic mul_a;
		logic mul_b;
		logic div_step;
		logic out_write;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic seg_hit;
		logic seg_last;
		logic div_done;
		logic out_free;
	} dp_status_t;

	// Joined breakpoint table: temperature at 0, sound at 17, light at 65.
	localparam logic [COUNT_W-1:0] PT_X [PT_N] = '{
		12'd55,   12'd216,  12'd400,  12'd755,  12'd1384, 12'd1813, 12'd2048,
		12'd2289, 12'd2530, 12'd2765, 12'd2985, 12'd3187, 12'd3366, 12'd3520,
		12'd3756, 12'd3907, 12'd4046,
		12'd0,    12'd3,    12'd4,    12'd5,    12'd6,    12'd7,    12'd8,
		12'd9,    12'd10,   12'd11,   12'd13,   12'd14,   12'd16,   12'd17,
		12'd19,   12'd23,   12'd28,   12'd34,   12'd41,   12'd50,   12'd61,
		12'd73,   12'd89,   12'd108,  12'd131,  12'd159,  12'd193,  12'd213,
		12'd242,  12'd275,  12'd313,  12'd357,  12'd406,  12'd462,  12'd526,
		12'd599,  12'd682,  12'd777,  12'd885,  12'd1007, 12'd1147, 12'd1305,
		12'd1486, 12'd1692, 12'd1926, 12'd2193, 12'd2497, 12'd2843,
		12'd0,    12'd410,  12'd819,  12'd1229, 12'd1638, 12'd2048, 12'd2457,
		12'd2867, 12'd3276, 12'd3686, 12'd4095
	};

	localparam logic signed [VALUE_W-1:0] PT_Y [PT_N] = '{
		12'sd1500, 12'sd1000, 12'sd800,  12'sd600,  12'sd400,  12'sd300,
		12'sd250,  12'sd200,  12'sd150,  12'sd100,  12'sd50,   12'sd0,
		-12'sd50,  -12'sd100, -12'sd200, -12'sd300, -12'sd500,
		12'sd550,  12'sd550,  12'sd570,  12'sd590,  12'sd600,  12'sd620,
		12'sd630,  12'sd650,  12'sd660,  12'sd670,  12'sd680,  12'sd690,
		12'sd700,  12'sd705,  12'sd710,  12'sd720,  12'sd730,  12'sd740,
		12'sd750,  12'sd760,  12'sd770,  12'sd780,  12'sd790,  12'sd800,
		12'sd810,  12'sd820,  12'sd830,  12'sd835,  12'sd840,  12'sd850,
		12'sd860,  12'sd870,  12'sd880,  12'sd890,  12'sd900,  12'sd910,
		12'sd920,  12'sd930,  12'sd940,  12'sd950,  12'sd960,  12'sd970,
		12'sd980,  12'sd990,  12'sd1000, 12'sd1010, 12'sd1020, 12'sd1030,
		12'sd0,    12'sd20,   12'sd40,   12'sd60,   12'sd110,  12'sd160,
		12'sd230,  12'sd320,  12'sd440,  12'sd620,  12'sd1000
	};

	// First entry of each kind's table in the joined table.
	function automatic logic [ADDR_W-1:0] kind_base(input kind_t k);
		logic [ADDR_W-1:0] b;
		unique case (k)
			KIND_TEMP:  b = 7'd0;
			KIND_SOUND: b = 7'd17;
			KIND_LIGHT: b = 7'd65;
			default:    b = 7'd0;
		endcase
		return b;
	endfunction

	// Number of breakpoints of each kind's table; the unused kind has none.
	function automatic logic [IDX_W-1:0] kind_npts(input kind_t k);
		logic [IDX_W-1:0] n;
		unique case (k)
			KIND_TEMP:  n = 6'd17;
			KIND_SOUND: n = 6'd48;
			KIND_LIGHT: n = 6'd11;
			default:    n = 6'd0;
		endcase
		return n;
	endfunction

endpackage

// File: rtl/spl_ctrl.sv
// ----------------------------------------------------------------------------
// spl_ctrl
// Controller of the linearizer: steps one item through segment search, the
// MUL_A and MUL_B states, the shift-subtract division and the result write.
// ----------------------------------------------------------------------------
module spl_ctrl import spl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				priority if (status.seg_hit) begin
					state_d = ST_MUL_A;
				end else if (status.seg_last) begin
					state_d = ST_WRITE;
				end else begin
					state_d = ST_SEARCH;
				end
			end
			ST_MUL_A: state_d = ST_MUL_B;
			ST_MUL_B: state_d = ST_DIVIDE;
			ST_DIVIDE: begin
				if (status.div_done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands and input handshake.
	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.search    = (state_q == ST_SEARCH);
		cmd.mul_a     = (state_q == ST_MUL_A);
		cmd.mul_b     = (state_q == ST_MUL_B);
		cmd.div_step  = (state_q == ST_DIVIDE);
		cmd.out_write = (state_q == ST_WRITE) && status.out_free;
	end

endmodule

// File: rtl/spl_datapath.sv
// ----------------------------------------------------------------------------
// spl_datapath
// Datapath of the linearizer: table search over one segment per cycle,
// numerator build in the mul_a and mul_b steps, restoring division one quotient
// bit per cycle, and the output register.
// ----------------------------------------------------------------------------
module spl_datapath import spl_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctrl_cmd_t                 cmd,
	output dp_status_t                status,
	input  logic [KIND_W-1:0]         kind,
	input  logic [COUNT_W-1:0]        adc_count,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] scaled_value,
	output logic                      out_of_range
);

	// Item and segment registers.
	kind_t                      kind_q;
	logic [COUNT_W-1:0]         count_q;
	logic [IDX_W-1:0]           idx_q;
	logic                       miss_q;
	logic signed [VALUE_W-1:0]  y0_q;
	logic [COUNT_W-1:0]         dx_q;
	logic signed [DY_W-1:0]     dy_q;
	logic [COUNT_W-1:0]         d_q;

	// Arithmetic registers.
	logic signed [PA_W-1:0]     prod_a_q;
	logic                       neg_q;
	logic [COUNT_W-1:0]         rem_q;
	logic [QUOT_W-1:0]          quo_q;
	logic [BIT_W-1:0]           bit_q;

	// Output register.
	logic                       out_valid_q;
	logic signed [VALUE_W-1:0]  value_q;
	logic                       oor_q;

	// Search signals.
	logic [ADDR_W-1:0]          addr;
	logic [ADDR_W-1:0]          addr_hi;
	logic [COUNT_W-1:0]         x_lo;
	logic [COUNT_W-1:0]         x_hi;
	logic signed [VALUE_W-1:0]  y_lo;
	logic signed [VALUE_W-1:0]  y_hi;
	logic                       hit;
	logic                       last;

	// Numerator and division signals.
	logic signed [PB_W-1:0]     prod_b;
	logic signed [NUM_W-1:0]    num;
	logic [NUM_W-1:0]           mag_full;
	logic [MAG_W-1:0]           mag;
	logic [COUNT_W:0]           trial;
	logic [COUNT_W:0]           diff;
	logic                       ge;
	logic [VALUE_W-1:0]         quo_ext;

	// Segment lookup: compare the count with breakpoints i and i+1.
	always_comb begin
		addr    = kind_base(kind_q) + {1'b0, idx_q};
		addr_hi = addr + ADDR_W'(1);
		x_lo    = PT_X[addr];
		x_hi    = PT_X[addr_hi];
		y_lo    = PT_Y[addr];
		y_hi    = PT_Y[addr_hi];
		hit     = (kind_q != KIND_NONE) && (count_q >= x_lo) && (count_q < x_hi);
		last    = (({1'b0, idx_q} + ADDR_W'(2)) >= {1'b0, kind_npts(kind_q)});
	end

	// Numerator y0*dx + d*dy, its sign and magnitude.
	always_comb begin
		prod_b   = $signed({1'b0, d_q}) * dy_q;
		num      = NUM_W'(prod_a_q) + NUM_W'(prod_b);
		mag_full = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		mag      = mag_full[MAG_W-1:0];
	end

	// One restoring division step.
	always_comb begin
		trial = {rem_q, quo_q[QUOT_W-1]};
		diff  = trial - {1'b0, dx_q};
		ge    = (trial >= {1'b0, dx_q});
	end

	assign quo_ext = {{(VALUE_W-QUOT_W){1'b0}}, quo_q};

	// Control registers: search index, miss flag and bit counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			miss_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			if (cmd.load) begin
				idx_q  <= '0;
				miss_q <= 1'b0;
			end else if (cmd.search && !hit) begin
				if (last) begin
					miss_q <= 1'b1;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			if (cmd.mul_b) begin
				bit_q <= '0;
			end else if (cmd.div_step) begin
				bit_q <= bit_q + BIT_W'(1);
			end
		end
	end

	// Payload registers of the item, the segment and the division.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind_t'(kind);
			count_q <= adc_count;
		end
		if (cmd.search && hit) begin
			y0_q <= y_lo;
			dx_q <= x_hi - x_lo;
			dy_q <= DY_W'(y_hi) - DY_W'(y_lo);
			d_q  <= count_q - x_lo;
		end
		if (cmd.mul_a) begin
			prod_a_q <= y0_q * $signed({1'b0, dx_q});
		end
		if (cmd.mul_b) begin
			neg_q <= num[NUM_W-1];
			rem_q <= mag[MAG_W-1:QUOT_W];
			quo_q <= mag[QUOT_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
			quo_q <= {quo_q[QUOT_W-2:0], ge};
		end
	end

	// Output register: holds the result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_write) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_write) begin
			oor_q <= miss_q;
			priority if (miss_q) begin
				value_q <= '1;
			end else if (neg_q) begin
				value_q <= $signed(VALUE_W'(0) - quo_ext);
			end else begin
				value_q <= $signed(quo_ext);
			end
		end
	end

	// Status to the controller.
	always_comb begin
		status.seg_hit  = hit;
		status.seg_last = last;
		status.div_done = (bit_q == BIT_W'(QUOT_W - 1));
		status.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid    = out_valid_q;
	assign scaled_value = value_q;
	assign out_of_range = oor_q;

endmodule

// File: rtl/sensor_piecewise_linearizer_top.sv
// ----------------------------------------------------------------------------
// sensor_piecewise_linearizer_top
// Converts a raw 12-bit converter count into an engineering value by
// linear interpolation in a fixed calibration table chosen by sensor kind.
// ----------------------------------------------------------------------------
// The block takes one item at a time and returns exactly one result for it:
// the value interpolated between the two breakpoints that enclose the count,
// truncated toward zero, or -1 with out_of_range set when no segment of the
// selected table holds the count (kind three has no table). From acceptance,
// the search tests one segment per cycle up to the matching segment k (0 to
// 46), the numerator takes the MUL_A and MUL_B states, the restoring divider
// takes one cycle per quotient bit for eleven bits, and the result is then
// written to the output register. A count that matches no segment returns
// once the whole table has been searched, and kind three goes straight from
// the search to the write. The worst case is the last sound segment. The
// controller is ready for the next item in the cycle after the result is
// written. A new item is taken as soon as the previous result sits in the
// output register, even while that result is still stalled.
module sensor_piecewise_linearizer_top import spl_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [KIND_W-1:0]         kind,
	input  logic [COUNT_W-1:0]        adc_count,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] scaled_value,
	output logic                      out_of_range
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Sequencer.
	spl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Search, arithmetic and output register.
	spl_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.kind         (kind),
		.adc_count    (adc_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.scaled_value (scaled_value),
		.out_of_range (out_of_range)
	);

endmodule

// File: rtl/spl_checker.sv
// ----------------------------------------------------------------------------
// spl_checker
// Port-level checks of the linearizer, bound to the top level.
// ----------------------------------------------------------------------------
module spl_checker import spl_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic [KIND_W-1:0]         kind,
	input logic [COUNT_W-1:0]        adc_count,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic signed [VALUE_W-1:0] scaled_value,
	input logic                      out_of_range
);

	// A stalled result stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(scaled_value)
			&& $stable(out_of_range))
		else $error("stalled result changed");

	// A miss always reports -1.
	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> scaled_value == -12'sd1)
		else $error("out of range result is not -1");

	// A hit stays within the calibration range.
	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_of_range |-> scaled_value >= -12'sd500
			&& scaled_value <= 12'sd1500)
		else $error("interpolated value outside calibration range");

	// An accepted item keeps the block busy once it enters the search.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block ready right after accepting an item");

	// No kind, the unused one included, shows a result right after its acceptance while the output is empty.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result appeared one cycle after accept");

endmodule

bind sensor_piecewise_linearizer_top spl_checker u_spl_checker (.*);
